// ----- hdl/shc_pkg.sv -----
// Shared types, constants and rounding helper for the SH degree-2 color unit.
// Used by the lane, basis and top modules in hdl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package shc_pkg;

  // Default highest basis number plus one
  localparam int unsigned MAX_BASIS_DEF = 9;

  // Iteration counts of the normalization units
  localparam int unsigned ROOT_STEPS = 24;
  localparam int unsigned DIV_STEPS  = 37;

  // Basis constants, Q3.12
  localparam logic signed [15:0] K_C1 = 16'sd2001;
  localparam logic signed [15:0] K_C2 = 16'sd4475;
  localparam logic signed [15:0] K_C3 = 16'sd1292;
  localparam logic signed [15:0] K_C4 = 16'sd2238;

  // Basis numbers
  localparam logic [3:0] BAS_Y    = 4'd1;
  localparam logic [3:0] BAS_Z    = 4'd2;
  localparam logic [3:0] BAS_X    = 4'd3;
  localparam logic [3:0] BAS_XY   = 4'd4;
  localparam logic [3:0] BAS_YZ   = 4'd5;
  localparam logic [3:0] BAS_ZZ   = 4'd6;
  localparam logic [3:0] BAS_XZ   = 4'd7;
  localparam logic [3:0] BAS_XXYY = 4'd8;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_SH_ENABLE = 3'd0;

  typedef struct packed {
    logic              first_term;
    logic              last_term;
    logic [3:0]        basis_index;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
    logic signed [15:0] dc_red;
    logic signed [15:0] dc_green;
    logic signed [15:0] dc_blue;
    logic signed [15:0] coef_red;
    logic signed [15:0] coef_green;
    logic signed [15:0] coef_blue;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_red;
    logic signed [15:0] out_green;
    logic signed [15:0] out_blue;
  } result_t;

  // Lane controls from the sequencer
  typedef struct packed {
    logic load_first;
    logic sq_en;
    logic div_start;
    logic div_step;
    logic unit_zero;
    logic unit_load;
    logic mac_en;
  } lane_ctrl_t;

  // Basis weight controls from the sequencer
  typedef struct packed {
    logic prod_en;
    logic prod2_en;
    logic wt_en;
  } basis_ctrl_t;

  // Round Q.12 product to nearest, ties up: floor((p + 2048) / 4096)
  function automatic logic signed [35:0] rnd12(input logic signed [47:0] p);
    logic signed [47:0] t;
    t = p + 48'sd2048;
    return 36'(t >>> 12);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/shc_isqrt.sv -----
// Bit-serial integer square root of (s << 16), one result bit per step.
// Depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

module shc_isqrt (
  input  wire logic        clk,
  input  wire logic        start,
  input  wire logic        step,
  input  wire logic [31:0] s,
  output logic      [23:0] root
);

  logic [47:0] rem;
  logic [47:0] rt;
  logic [47:0] bt;
  logic [47:0] trial;

  assign trial = rt + bt;
  assign root  = rt[23:0];

  // One digit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {s, 16'b0};
      rt  <= '0;
      bt  <= 48'h4000_0000_0000;
    end else if (step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        rt  <= (rt >> 1) + bt;
      end else begin
        rt  <= rt >> 1;
      end
      bt <= bt >> 2;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/shc_lane.sv -----
// One lane: square and normalizing divider for one axis, accumulator for one channel.
// Depends on shc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shc_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire shc_pkg::lane_ctrl_t ctrl,
  input  wire logic signed [15:0]  view,
  input  wire logic signed [15:0]  dc,
  input  wire logic signed [15:0]  coef,
  input  wire logic [23:0]         q,
  input  wire logic signed [17:0]  w,
  output logic [31:0]              sq,
  output logic signed [15:0]       unit,
  output logic signed [31:0]       acc
);

  logic signed [31:0] sq_prod;
  logic signed [16:0] vx;
  logic [16:0]        mag;
  logic [36:0]        dvd;
  logic [36:0]        dvd_init;
  logic [23:0]        rem;
  logic [24:0]        rem_sh;
  logic               ge;
  logic [23:0]        rem_next;
  logic [15:0]        quo;
  logic               neg;
  logic signed [33:0] mprod;
  logic signed [33:0] term;
  logic signed [33:0] sum;
  logic signed [31:0] acc_next;

  // Square of the raw component
  assign sq_prod = view * view;

  // Divider setup: |v| * 2^20 + q/2
  assign vx       = 17'(view);
  assign mag      = vx[16] ? 17'(-vx) : 17'(vx);
  assign dvd_init = 37'({mag[15:0], 20'b0}) + 37'(q[23:1]);

  // Restoring divide step
  assign rem_sh   = {rem, dvd[36]};
  assign ge       = rem_sh >= {1'b0, q};
  assign rem_next = ge ? 24'(rem_sh - {1'b0, q}) : rem_sh[23:0];

  // Multiply-accumulate with saturation
  assign mprod = coef * w;
  assign term  = 34'(shc_pkg::rnd12(48'(mprod)));
  assign sum   = 34'(acc) + term;
  always_comb begin
    if (sum > 34'sh0_7FFF_FFFF) begin
      acc_next = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      acc_next = 32'sh8000_0000;
    end else begin
      acc_next = 32'(sum);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.sq_en) begin
      sq <= 32'(sq_prod);
    end
    if (ctrl.div_start) begin
      dvd <= dvd_init;
      rem <= '0;
      quo <= '0;
      neg <= view[15];
    end else if (ctrl.div_step) begin
      dvd <= dvd << 1;
      rem <= rem_next;
      quo <= {quo[14:0], ge};
    end
  end

  // Lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= '0;
      acc  <= '0;
    end else begin
      if (ctrl.unit_zero) begin
        unit <= '0;
      end else if (ctrl.unit_load) begin
        unit <= neg ? -$signed(quo) : $signed(quo);
      end
      if (ctrl.load_first) begin
        acc <= 32'(dc);
      end else if (ctrl.mac_en) begin
        acc <= acc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/shc_basis.sv -----
// Merge stage: combines the three lane unit components into one basis weight.
// Depends on shc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shc_basis (
  input  wire logic                 clk,
  input  wire shc_pkg::basis_ctrl_t ctrl,
  input  wire logic [3:0]           basis,
  input  wire logic signed [15:0]   ux,
  input  wire logic signed [15:0]   uy,
  input  wire logic signed [15:0]   uz,
  output logic signed [17:0]        w
);

  logic signed [15:0] pa;
  logic signed [15:0] pb;
  logic signed [31:0] prod;
  logic signed [31:0] prod_yy;
  logic signed [17:0] p1;
  logic signed [17:0] p2;
  logic signed [17:0] t;
  logic signed [15:0] k;
  logic               wneg;
  logic signed [33:0] kprod;
  logic signed [17:0] r;

  // Product operands per basis
  always_comb begin
    case (basis)
      shc_pkg::BAS_XY:   begin pa = ux; pb = uy; end
      shc_pkg::BAS_YZ:   begin pa = uy; pb = uz; end
      shc_pkg::BAS_ZZ:   begin pa = uz; pb = uz; end
      shc_pkg::BAS_XZ:   begin pa = ux; pb = uz; end
      shc_pkg::BAS_XXYY: begin pa = ux; pb = ux; end
      default:           begin pa = ux; pb = uy; end
    endcase
  end

  assign prod    = pa * pb;
  assign prod_yy = uy * uy;

  // Constant, polynomial and sign per basis
  always_comb begin
    case (basis)
      shc_pkg::BAS_Y:    begin t = 18'(uy); k = shc_pkg::K_C1; wneg = 1'b1; end
      shc_pkg::BAS_Z:    begin t = 18'(uz); k = shc_pkg::K_C1; wneg = 1'b0; end
      shc_pkg::BAS_X:    begin t = 18'(ux); k = shc_pkg::K_C1; wneg = 1'b1; end
      shc_pkg::BAS_XY:   begin t = p1;      k = shc_pkg::K_C2; wneg = 1'b0; end
      shc_pkg::BAS_YZ:   begin t = p1;      k = shc_pkg::K_C2; wneg = 1'b1; end
      shc_pkg::BAS_ZZ: begin
        t = (p1 <<< 1) + p1 - 18'sd4096;
        k = shc_pkg::K_C3;
        wneg = 1'b0;
      end
      shc_pkg::BAS_XZ:   begin t = p1;      k = shc_pkg::K_C2; wneg = 1'b1; end
      shc_pkg::BAS_XXYY: begin t = p1 - p2; k = shc_pkg::K_C4; wneg = 1'b0; end
      default:           begin t = '0;      k = '0;            wneg = 1'b0; end
    endcase
  end

  assign kprod = k * t;
  assign r     = 18'(shc_pkg::rnd12(48'(kprod)));

  // Registered after each multiply
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      p1 <= 18'(shc_pkg::rnd12(48'(prod)));
    end
    if (ctrl.prod2_en) begin
      p2 <= 18'(shc_pkg::rnd12(48'(prod_yy)));
    end
    if (ctrl.wt_en) begin
      w <= wneg ? -r : r;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sh_degree2_color_eval_unit.sv -----
// SH degree-2 color unit: one splat term per item, view-dependent RGB out.
// Input and output travel on valid/stall channels; one enable register on an
// APB-style port. Only a transfer that carries last_term yields a result.
// Steps:
//   item with first_term: square, 24-step square root, 37-step normalizing
//   divide (the three axes divide in parallel lanes) and unit load, all but
//   the square skipped for a zero direction, before the term below.
//   term item with an active basis: product, weight and multiply-accumulate
//   steps (an extra product step for the xx-yy basis), then emit if last_term.
//   item whose basis adds nothing: emit only if it carries last_term.
// One item is in flight at a time; item_stall is high while it works.
// The result sits in an output register; while result_stall holds it, the
// unit still accepts and works the next item and waits only when that item
// must emit too.
// Reset (rst, synchronous): accumulators, unit vector and the added flag
// clear, sh_enable becomes 1, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module sh_degree2_color_eval_unit #(
  parameter int unsigned MAX_BASIS = shc_pkg::MAX_BASIS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire shc_pkg::item_t              item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output shc_pkg::result_t                 result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [shc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CNT_W = $clog2(shc_pkg::DIV_STEPS);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_SQ      = 12'b0000_0000_0010,
    ST_ROOTSET = 12'b0000_0000_0100,
    ST_ROOT    = 12'b0000_0000_1000,
    ST_DIVSET  = 12'b0000_0001_0000,
    ST_DIV     = 12'b0000_0010_0000,
    ST_UNIT    = 12'b0000_0100_0000,
    ST_PROD    = 12'b0000_1000_0000,
    ST_PROD2   = 12'b0001_0000_0000,
    ST_WEIGHT  = 12'b0010_0000_0000,
    ST_MAC     = 12'b0100_0000_0000,
    ST_EMIT    = 12'b1000_0000_0000
  } state_t;

  state_t               state;
  state_t               state_next;
  shc_pkg::item_t       item_q;
  logic                 sh_enable;
  logic                 terms_added;
  logic [CNT_W-1:0]     cnt;
  logic                 accept;
  logic                 emit_load;
  shc_pkg::lane_ctrl_t  lctl;
  shc_pkg::basis_ctrl_t bctl;
  logic                 root_start;
  logic                 root_step;
  logic [23:0]          root;
  logic [31:0]          sq_x;
  logic [31:0]          sq_y;
  logic [31:0]          sq_z;
  logic [31:0]          s_sum;
  logic signed [15:0]   ux;
  logic signed [15:0]   uy;
  logic signed [15:0]   uz;
  logic signed [31:0]   acc_r;
  logic signed [31:0]   acc_g;
  logic signed [31:0]   acc_b;
  logic signed [17:0]   w;
  state_t               post_state;

  function automatic logic term_hit(input logic [3:0] b, input logic en);
    return en && (b != 4'd0) && ({1'b0, b} < 5'(MAX_BASIS)) && (b <= shc_pkg::BAS_XXYY);
  endfunction

  function automatic logic signed [15:0] out_of(input logic signed [31:0] a,
                                                input logic added);
    logic signed [31:0] c;
    c = a;
    if (added) begin
      if (a < 0) begin
        c = '0;
      end else if (a > 32'sd4096) begin
        c = 32'sd4096;
      end
    end
    return c[15:0];
  endfunction

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign emit_load  = (state == ST_EMIT) && (!result_valid || !result_stall);
  assign s_sum      = sq_x + sq_y + sq_z;

  // Where a splat goes after its load phase
  assign post_state = term_hit(item_q.basis_index, sh_enable) ? ST_PROD :
                      (item_q.last_term ? ST_EMIT : ST_IDLE);

  // Sequencer
  always_comb begin
    state_next = state;
    lctl       = '0;
    bctl       = '0;
    root_start = 1'b0;
    root_step  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.first_term) begin
            lctl.load_first = 1'b1;
            state_next      = ST_SQ;
          end else if (term_hit(item.basis_index, sh_enable)) begin
            state_next = ST_PROD;
          end else if (item.last_term) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SQ: begin
        lctl.sq_en = 1'b1;
        state_next = ST_ROOTSET;
      end
      ST_ROOTSET: begin
        if (s_sum == '0) begin
          lctl.unit_zero = 1'b1;
          state_next     = post_state;
        end else begin
          root_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        root_step = 1'b1;
        if (cnt == CNT_W'(shc_pkg::ROOT_STEPS - 1)) begin
          state_next = ST_DIVSET;
        end
      end
      ST_DIVSET: begin
        lctl.div_start = 1'b1;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        lctl.div_step = 1'b1;
        if (cnt == CNT_W'(shc_pkg::DIV_STEPS - 1)) begin
          state_next = ST_UNIT;
        end
      end
      ST_UNIT: begin
        lctl.unit_load = 1'b1;
        state_next     = post_state;
      end
      ST_PROD: begin
        bctl.prod_en = 1'b1;
        state_next   = (item_q.basis_index == shc_pkg::BAS_XXYY) ? ST_PROD2 : ST_WEIGHT;
      end
      ST_PROD2: begin
        bctl.prod2_en = 1'b1;
        state_next    = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        bctl.wt_en = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        lctl.mac_en = 1'b1;
        state_next  = item_q.last_term ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      terms_added  <= 1'b0;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (lctl.load_first) begin
        terms_added <= 1'b0;
      end else if (lctl.mac_en) begin
        terms_added <= 1'b1;
      end
      if (root_start || lctl.div_start) begin
        cnt <= '0;
      end else if (root_step || lctl.div_step) begin
        cnt <= cnt + 1'b1;
      end
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (emit_load) begin
      result.out_red   <= out_of(acc_r, terms_added);
      result.out_green <= out_of(acc_g, terms_added);
      result.out_blue  <= out_of(acc_b, terms_added);
    end
  end

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_enable <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == shc_pkg::ADDR_SH_ENABLE[2])) begin
      sh_enable <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == shc_pkg::ADDR_SH_ENABLE[2]) ? {31'b0, sh_enable} : 32'b0;

  // Square root of the squared length
  shc_isqrt u_isqrt (
    .clk   (clk),
    .start (root_start),
    .step  (root_step),
    .s     (s_sum),
    .root  (root)
  );

  // Lanes: axis x / red, y / green, z / blue
  shc_lane u_lane_r (
    .clk (clk), .rst (rst), .ctrl (lctl),
    .view (item_q.view_x), .dc (item.dc_red), .coef (item_q.coef_red),
    .q (root), .w (w), .sq (sq_x), .unit (ux), .acc (acc_r)
  );
  shc_lane u_lane_g (
    .clk (clk), .rst (rst), .ctrl (lctl),
    .view (item_q.view_y), .dc (item.dc_green), .coef (item_q.coef_green),
    .q (root), .w (w), .sq (sq_y), .unit (uy), .acc (acc_g)
  );
  shc_lane u_lane_b (
    .clk (clk), .rst (rst), .ctrl (lctl),
    .view (item_q.view_z), .dc (item.dc_blue), .coef (item_q.coef_blue),
    .q (root), .w (w), .sq (sq_z), .unit (uz), .acc (acc_b)
  );

  // Basis weight from the merged unit vector
  shc_basis u_basis (
    .clk   (clk),
    .ctrl  (bctl),
    .basis (item_q.basis_index),
    .ux    (ux),
    .uy    (uy),
    .uz    (uz),
    .w     (w)
  );

  // Checks
  a_added_from_mac: assert property (@(posedge clk) disable iff (rst)
    $rose(terms_added) |-> $past(state == ST_MAC))
    else $error("terms_added set outside accumulate step");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared without emit step");

  a_root_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) && (cnt == CNT_W'(shc_pkg::ROOT_STEPS - 1)) |=> (state == ST_DIVSET))
    else $error("square root ran wrong number of steps");

endmodule

`default_nettype wire
